[src/srafr_pkg.sv]
`timescale 1ns / 1ps
package srafr_pkg;

    localparam int FrameLen = 17;
    localparam int CountW   = $clog2(FrameLen + 1);
    localparam int HeadLen  = 5;
    localparam int TailLen  = 2;

    typedef logic [7:0] t_char;

    // One frame byte as it sits in a cell of the output chain.
    typedef struct packed {
        logic  last;
        t_char data;
    } t_beat;

    localparam t_char AsciiZero = 8'h30;

    // "smart" and "ok"
    localparam t_char HeadChars [HeadLen] = '{8'h73, 8'h6D, 8'h61, 8'h72, 8'h74};
    localparam t_char TailChars [TailLen] = '{8'h6F, 8'h6B};

endpackage

[src/srafr_digit.sv]
`timescale 1ns / 1ps
module srafr_digit (
    input  srafr_pkg::t_char i_value,
    output srafr_pkg::t_char o_tens,
    output srafr_pkg::t_char o_ones
);
    import srafr_pkg::*;

    logic [15:0] w_prod;
    logic [4:0]  w_quot;
    logic [7:0]  w_quot10;
    logic [7:0]  w_ones;
    logic [4:0]  w_tens;

    // x / 10 for 8-bit x: (x * 205) >> 11 is exact over the whole range
    assign w_prod   = {8'd0, i_value} * 16'd205;
    assign w_quot   = w_prod[15:11];
    assign w_quot10 = {w_quot, 3'b000} + {2'b00, w_quot, 1'b0};
    assign w_ones   = i_value - w_quot10;

    // quotient is at most 25: drop the hundreds by subtracting twenty or ten
    always_comb begin
        if (w_quot >= 5'd20) begin
            w_tens = w_quot - 5'd20;
        end else if (w_quot >= 5'd10) begin
            w_tens = w_quot - 5'd10;
        end else begin
            w_tens = w_quot;
        end
    end

    assign o_tens = AsciiZero + {3'b000, w_tens};
    assign o_ones = AsciiZero + {4'b0000, w_ones[3:0]};

endmodule

[src/srafr_cell.sv]
`timescale 1ns / 1ps
module srafr_cell (
    input  logic             i_clk,
    input  logic             i_load,
    input  logic             i_shift,
    input  srafr_pkg::t_beat i_load_beat,
    input  srafr_pkg::t_beat i_next_beat,
    output srafr_pkg::t_beat o_beat
);
    import srafr_pkg::*;

    t_beat r_beat;
    t_beat n_beat;

    // load a fresh frame byte, or take the neighbour's byte on a shift
    always_comb begin
        n_beat = r_beat;
        if (i_load) begin
            n_beat = i_load_beat;
        end else if (i_shift) begin
            n_beat = i_next_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_beat <= n_beat;
    end

    assign o_beat = r_beat;

endmodule

[src/sensor_report_ascii_framer_unit.sv]
`timescale 1ns / 1ps
// Sensor report ASCII framer.
// Input channel (s_axis_*): one transfer carries one report of six 8-bit
// readings. Output channel (m_axis_*): seventeen byte transfers per report,
// "smart", the tens and ones digits of temperature, humidity, smoke and
// danger level, the ones digit of danger kind and valve state, then "ok".
// m_axis_tlast marks the seventeenth byte.
// The frame is built in one go when a report is taken and loaded into a
// chain of seventeen byte cells; the head cell drives the output, and every
// output transfer moves each byte one cell towards the head.
// The first byte is offered in the cycle after the report transfer.
// A report holds the chain until all its bytes leave on the one-byte output channel.
// A new report is taken in the same cycle as the final byte leaves, so an
// unstalled receiver sees a gapless byte stream.
// When the receiver stalls, the chain holds and s_axis_tready stays low
// until the last byte of the current frame goes.
// Reset (synchronous, active low) empties the chain; no output is valid and
// the input is ready straight after.
module sensor_report_ascii_framer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] temperature_value, [15:8] humidity_value, [23:16] smoke_value,
    // [31:24] danger_level, [39:32] danger_kind, [47:40] valve_state
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] frame_byte
    output logic [7:0]  m_axis_tdata,
    // last_byte
    output logic        m_axis_tlast
);
    import srafr_pkg::*;

    localparam int NumReadings = 6;

    logic [CountW-1:0] r_count;
    logic [CountW-1:0] n_count;
    logic              w_in_xfer;
    logic              w_out_xfer;

    t_char w_tens [NumReadings];
    t_char w_ones [NumReadings];
    t_beat w_load [FrameLen];
    t_beat w_cell [FrameLen + 1];

    // Digit conversion of each reading; only the first four send their tens.
    for (genvar k = 0; k < NumReadings; k++) begin : g_digit
        srafr_digit u_digit (
            .i_value (s_axis_tdata[8*k +: 8]),
            .o_tens  (w_tens[k]),
            .o_ones  (w_ones[k])
        );
    end

    // Assemble the frame in transfer order.
    always_comb begin
        for (int j = 0; j < FrameLen; j++) begin
            w_load[j].last = 1'b0;
        end
        for (int j = 0; j < HeadLen; j++) begin
            w_load[j].data = HeadChars[j];
        end
        for (int j = 0; j < 4; j++) begin
            w_load[HeadLen + 2*j].data     = w_tens[j];
            w_load[HeadLen + 2*j + 1].data = w_ones[j];
        end
        w_load[HeadLen + 8].data  = w_ones[4];
        w_load[HeadLen + 9].data  = w_ones[5];
        w_load[HeadLen + 10].data = TailChars[0];
        w_load[HeadLen + 11].data = TailChars[1];
        w_load[FrameLen-1].last   = 1'b1;
    end

    // Chain of byte cells; the cell past the tail feeds in nothing.
    assign w_cell[FrameLen] = '0;

    for (genvar c = 0; c < FrameLen; c++) begin : g_cell
        srafr_cell u_cell (
            .i_clk       (i_clk),
            .i_load      (w_in_xfer),
            .i_shift     (w_out_xfer),
            .i_load_beat (w_load[c]),
            .i_next_beat (w_cell[c+1]),
            .o_beat      (w_cell[c])
        );
    end

    // Handshakes: accept a report when the chain is empty or its final byte
    // leaves in this cycle.
    assign m_axis_tvalid = (r_count != '0);
    assign s_axis_tready = (r_count == '0)
                        || ((r_count == CountW'(1)) && m_axis_tready);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_out_xfer    = m_axis_tvalid && m_axis_tready;

    assign m_axis_tdata  = w_cell[0].data;
    assign m_axis_tlast  = w_cell[0].last;

    // Bytes left in the chain: reload to a full frame, count down per byte.
    always_comb begin
        n_count = r_count;
        if (w_in_xfer) begin
            n_count = CountW'(FrameLen);
        end else if (w_out_xfer) begin
            n_count = r_count - CountW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for the sensor report ASCII framer.
// Report transfers go in on the input stream; a predictor builds the
// seventeen frame bytes that each accepted report should produce and
// queues them. A monitor compares every output transfer, byte and last
// flag, with the oldest queued byte. Both sides idle at random, with one
// long stretch in which neither side idles.
module tb_top;
    import srafr_pkg::*;

    localparam int CycleLimit  = 200000;
    localparam int IdlePercent = 8;
    localparam int TailCycles  = 40;

    // ASCII header and trailer, first character in the highest byte
    localparam logic [39:0] FrameHead = "smart";
    localparam logic [15:0] FrameTail = "ok";
    localparam t_char       DigitZero = 8'h30;

    // Packed so that temperature lands in the lowest byte of tdata.
    typedef struct packed {
        logic [7:0] valve_state;
        logic [7:0] danger_kind;
        logic [7:0] danger_level;
        logic [7:0] smoke_value;
        logic [7:0] humidity_value;
        logic [7:0] temperature_value;
    } t_report;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    t_beat       frame_bytes_due [$];
    int          error_count     = 0;
    int          cycle_count     = 0;
    bit          idling_enabled  = 1'b1;

    sensor_report_ascii_framer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic bit side_idles();
        return idling_enabled && ($urandom_range(99) < IdlePercent);
    endfunction

    function automatic t_char ones_digit(input logic [7:0] v);
        return DigitZero + t_char'(v % 8'd10);
    endfunction

    function automatic t_char tens_digit(input logic [7:0] v);
        return DigitZero + t_char'((v / 8'd10) % 8'd10);
    endfunction

    // Build the expected frame for one report and queue it byte by byte.
    function automatic void predict_frame(input t_report r);
        t_char       frame [FrameLen];
        logic [7:0]  pair_fields [4];
        int          pos;
        pos            = 0;
        pair_fields[0] = r.temperature_value;
        pair_fields[1] = r.humidity_value;
        pair_fields[2] = r.smoke_value;
        pair_fields[3] = r.danger_level;
        for (int k = 0; k < 5; k++) begin
            frame[pos] = FrameHead[8*(4-k) +: 8];
            pos++;
        end
        for (int k = 0; k < 4; k++) begin
            frame[pos]     = tens_digit(pair_fields[k]);
            frame[pos + 1] = ones_digit(pair_fields[k]);
            pos += 2;
        end
        frame[pos]     = ones_digit(r.danger_kind);
        frame[pos + 1] = ones_digit(r.valve_state);
        frame[pos + 2] = FrameTail[15:8];
        frame[pos + 3] = FrameTail[7:0];
        for (int k = 0; k < FrameLen; k++) begin
            frame_bytes_due.push_back('{last: (k == FrameLen - 1), data: frame[k]});
        end
    endfunction

    // Offer one report, holding it until the transfer happens. The valid is
    // only lowered for an idle gap, so it is never lowered and raised in one step.
    task automatic send_report(input t_report r);
        while (side_idles()) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_frame(r);
    endtask

    function automatic t_report uniform_report(input logic [7:0] v);
        return '{v, v, v, v, v, v};
    endfunction

    // All-zero and all-ones readings, single bits, and mixed extremes.
    task automatic test_frame_extremes();
        send_report(uniform_report(8'd0));
        send_report(uniform_report(8'd255));
        send_report('{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255});
        send_report('{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0});
        for (int b = 0; b < 8; b++) begin
            send_report(uniform_report(8'(1 << b)));
        end
    endtask

    // Readings either side of the decimal roll-overs: one digit, two digits,
    // hundreds dropped, and type and valve codes of ten or more.
    task automatic test_digit_boundaries();
        logic [7:0] edges [10];
        edges = '{8'd9, 8'd10, 8'd99, 8'd100, 8'd109, 8'd110, 8'd199, 8'd200,
                  8'd209, 8'd250};
        for (int k = 0; k < 10; k++) begin
            send_report('{edges[(k + 5) % 10], edges[(k + 4) % 10], edges[(k + 3) % 10],
                          edges[(k + 2) % 10], edges[(k + 1) % 10], edges[k]});
        end
    endtask

    // Random reports: idling, then a stretch with none, then idling again.
    task automatic test_random_reports();
        t_report r;
        for (int n = 0; n < 350; n++) begin
            idling_enabled = !(n >= 120 && n < 240);
            r = '{8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255))};
            send_report(r);
        end
        idling_enabled = 1'b1;
    endtask

    // Receiver: stall at random.
    always @(posedge i_clk) begin
        m_axis_tready <= !side_idles();
    end

    // Compare each output transfer with the oldest expected byte.
    always @(posedge i_clk) begin
        t_beat due;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (frame_bytes_due.size() == 0) begin
                $error("unexpected frame byte %h last %b", m_axis_tdata, m_axis_tlast);
                error_count++;
            end else begin
                due = frame_bytes_due.pop_front();
                if (m_axis_tdata !== due.data) begin
                    $error("frame_byte: expected %h, actual %h", due.data, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tlast !== due.last) begin
                    $error("last_byte: expected %b, actual %b", due.last, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_frame_extremes();
        test_digit_boundaries();
        test_random_reports();
        s_axis_tvalid <= 1'b0;
        while (frame_bytes_due.size() != 0) @(posedge i_clk);
        repeat (TailCycles) @(posedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
